// ===== hw/rtl/gmc_pkg.sv =====
package gmc_pkg;

   // Field widths fixed by the interface
   localparam int CFG_W     = 5;
   localparam int CFG_IDX_W = 1;
   localparam int IDX_W     = 10;

   // Configuration register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 1'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 1'd1;

   // Request operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   // Direction codes
   localparam logic [1:0] DIR_ROW_INC = 2'd0;
   localparam logic [1:0] DIR_COL_INC = 2'd1;
   localparam logic [1:0] DIR_ROW_DEC = 2'd2;
   localparam logic [1:0] DIR_COL_DEC = 2'd3;

   localparam logic [3:0] ALL_TRIED = 4'hF;

   typedef struct packed {
      logic       operation;
      logic [1:0] direction;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] cell_index;
      logic             finished;
      logic             last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SINDEX,
      ST_OPEN,
      ST_INDEX,
      ST_READ,
      ST_TEST,
      ST_WALL,
      ST_NEW,
      ST_POPCHK,
      ST_POPLD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start_load;
      logic draw_load;
      logic clear_wr;
      logic calc_idx;
      logic grid_read;
      logic wall_wr;
      logic new_wr;
      logic open_start;
      logic pop_read;
      logic pop_load;
      logic pop_last;
      logic fin_emit;
   } cmd_type;

   typedef struct packed {
      logic tried_hit;
      logic maze_done;
      logic tgt_ok;
      logic cell_open;
      logic all_tried;
      logic count_one;
      logic out_free;
      logic clear_last;
   } status_type;

endpackage

// ===== hw/rtl/gmc_ctrl.sv =====
module gmc_ctrl import gmc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  req_type    req_data,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.operation)
                  OP_START: state_in = ST_CLEAR;
                  OP_DRAW: begin
                     if (!status.maze_done && !status.tried_hit) begin
                        state_in = ST_INDEX;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = status.tgt_ok ? ST_SINDEX : ST_FINISH;
            end
         end
         ST_SINDEX: state_in = ST_OPEN;
         ST_OPEN:   state_in = ST_IDLE;
         ST_INDEX:  state_in = status.tgt_ok ? ST_READ : ST_POPCHK;
         ST_READ:   state_in = ST_TEST;
         ST_TEST:   state_in = status.cell_open ? ST_POPCHK : ST_WALL;
         ST_WALL: begin
            if (status.out_free) begin
               state_in = ST_NEW;
            end
         end
         ST_NEW: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POPCHK: begin
            if (!status.all_tried) begin
               state_in = ST_IDLE;
            end else if (status.count_one) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_POPLD;
            end
         end
         ST_POPLD: state_in = ST_POPCHK;
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.operation)
                  OP_START: cmd.start_load = 1'b1;
                  OP_DRAW: cmd.draw_load = !status.maze_done && !status.tried_hit;
                  default: cmd = '0;
               endcase
            end
         end
         ST_CLEAR:  cmd.clear_wr   = 1'b1;
         ST_SINDEX: cmd.calc_idx   = 1'b1;
         ST_OPEN:   cmd.open_start = 1'b1;
         ST_INDEX:  cmd.calc_idx   = status.tgt_ok;
         ST_READ:   cmd.grid_read  = 1'b1;
         ST_WALL:   cmd.wall_wr    = status.out_free;
         ST_NEW:    cmd.new_wr     = status.out_free;
         ST_POPCHK: begin
            if (status.all_tried) begin
               cmd.pop_last = status.count_one;
               cmd.pop_read = !status.count_one;
            end
         end
         ST_POPLD:  cmd.pop_load = 1'b1;
         ST_FINISH: cmd.fin_emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

// ===== hw/rtl/gmc_datapath.sv =====
module gmc_datapath import gmc_pkg::*; #(
   parameter int GRID_ROWS   = 25,
   parameter int GRID_COLS   = 25,
   parameter int STACK_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  logic                 csr_valid,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   localparam int NCELLS = GRID_ROWS * GRID_COLS;
   localparam int AW     = $clog2(NCELLS);
   localparam int RW     = $clog2(GRID_ROWS);
   localparam int KW     = $clog2(GRID_COLS);
   localparam int SW     = $clog2(STACK_DEPTH);
   localparam int CNTW   = $clog2(STACK_DEPTH + 1);
   localparam int MW     = (RW > KW) ? RW : KW;
   localparam int EW     = ((MW > CFG_W) ? MW : CFG_W) + 2;
   localparam int SEW    = RW + KW + 4;

   localparam logic [AW-1:0]   COLS_A   = AW'(GRID_COLS);
   localparam logic [AW-1:0]   LAST_A   = AW'(NCELLS - 1);
   localparam logic [EW-1:0]   ROW_LIM  = EW'(GRID_ROWS - 1);
   localparam logic [EW-1:0]   COL_LIM  = EW'(GRID_COLS - 1);
   localparam logic [EW-1:0]   STEP2    = EW'(2);
   localparam logic [CNTW-1:0] CNT_FULL = CNTW'(STACK_DEPTH);

   // configuration
   logic [CFG_W-1:0] start_row_ff, start_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff <= CFG_W'(1);
         start_col_ff <= CFG_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CFG_START_ROW: start_row_ff <= csr_wdata;
            CFG_START_COL: start_col_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state registers
   logic [RW-1:0]   top_row_ff, top_row_in;
   logic [KW-1:0]   top_col_ff, top_col_in;
   logic [3:0]      top_tried_ff, top_tried_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            done_ff, done_in;
   logic [1:0]      dir_ff;
   logic [RW-1:0]   tgt_row_ff;
   logic [KW-1:0]   tgt_col_ff;
   logic            tgt_ok_ff;
   logic [AW-1:0]   nidx_ff, widx_ff, widx_in;
   logic [AW-1:0]   clr_addr_ff;
   logic            grid_rdata_ff;
   logic [SEW-1:0]  stk_rdata_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   logic grid_mem [NCELLS];
   logic [SEW-1:0] stk_mem [STACK_DEPTH];

   // target of a draw, taken from the top cell
   logic [EW-1:0] r_e, c_e, nr_e, nc_e, sr_e, sc_e;
   logic          tgt_inner, start_inner, draw_ok;

   always_comb begin
      r_e  = EW'(top_row_ff);
      c_e  = EW'(top_col_ff);
      nr_e = r_e;
      nc_e = c_e;
      case (req_data.direction)
         DIR_ROW_INC: nr_e = r_e + STEP2;
         DIR_COL_INC: nc_e = c_e + STEP2;
         DIR_ROW_DEC: nr_e = r_e - STEP2;
         DIR_COL_DEC: nc_e = c_e - STEP2;
         default:     nr_e = r_e;
      endcase
      // a wrapped negative value fails the upper bound test
      tgt_inner = (nr_e != '0) && (nr_e < ROW_LIM) && (nc_e != '0) && (nc_e < COL_LIM);
      draw_ok   = tgt_inner && (count_ff < CNT_FULL);
      sr_e      = EW'(start_row_ff);
      sc_e      = EW'(start_col_ff);
      start_inner = (sr_e != '0) && (sr_e < ROW_LIM) && (sc_e != '0) && (sc_e < COL_LIM);
   end

   always_ff @(posedge clock) begin
      if (cmd.start_load) begin
         tgt_row_ff <= RW'(start_row_ff);
         tgt_col_ff <= KW'(start_col_ff);
         tgt_ok_ff  <= start_inner;
      end else if (cmd.draw_load) begin
         dir_ff     <= req_data.direction;
         tgt_row_ff <= RW'(nr_e);
         tgt_col_ff <= KW'(nc_e);
         tgt_ok_ff  <= draw_ok;
      end
   end

   // cell index
   always_ff @(posedge clock) begin
      if (cmd.calc_idx) begin
         nidx_ff <= AW'(tgt_row_ff) * COLS_A + AW'(tgt_col_ff);
      end
   end

   always_comb begin
      case (dir_ff)
         DIR_ROW_INC: widx_in = nidx_ff - COLS_A;
         DIR_COL_INC: widx_in = nidx_ff - AW'(1);
         DIR_ROW_DEC: widx_in = nidx_ff + COLS_A;
         DIR_COL_DEC: widx_in = nidx_ff + AW'(1);
         default:     widx_in = nidx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.grid_read) begin
         widx_ff <= widx_in;
      end
   end

   // clear sweep address
   always_ff @(posedge clock) begin
      if (reset || cmd.start_load) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // grid memory, one write and one registered read per cycle
   logic          grid_we, grid_wdata;
   logic [AW-1:0] grid_waddr;

   always_comb begin
      grid_we    = cmd.clear_wr || cmd.wall_wr || cmd.new_wr || cmd.open_start;
      grid_wdata = !cmd.clear_wr;
      if (cmd.clear_wr) begin
         grid_waddr = clr_addr_ff;
      end else if (cmd.wall_wr) begin
         grid_waddr = widx_ff;
      end else begin
         grid_waddr = nidx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= grid_wdata;
      end
      if (cmd.grid_read) begin
         grid_rdata_ff <= grid_mem[nidx_ff];
      end
   end

   // stack: top entry in flops, entries below it in memory
   logic [CNTW-1:0] cnt_m1, cnt_m2;

   assign cnt_m1 = count_ff - CNTW'(1);
   assign cnt_m2 = count_ff - CNTW'(2);

   always_ff @(posedge clock) begin
      if (cmd.new_wr) begin
         stk_mem[cnt_m1[SW-1:0]] <= {top_row_ff, top_col_ff, top_tried_ff};
      end
      if (cmd.pop_read) begin
         stk_rdata_ff <= stk_mem[cnt_m2[SW-1:0]];
      end
   end

   always_comb begin
      top_row_in   = top_row_ff;
      top_col_in   = top_col_ff;
      top_tried_in = top_tried_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      if (cmd.start_load) begin
         count_in = '0;
         done_in  = 1'b1;
      end
      if (cmd.draw_load) begin
         top_tried_in = top_tried_ff | (4'b0001 << req_data.direction);
      end
      if (cmd.new_wr || cmd.open_start) begin
         top_row_in   = tgt_row_ff;
         top_col_in   = tgt_col_ff;
         top_tried_in = '0;
      end
      if (cmd.new_wr) begin
         count_in = count_ff + CNTW'(1);
      end
      if (cmd.open_start) begin
         count_in = CNTW'(1);
         done_in  = 1'b0;
      end
      if (cmd.pop_read) begin
         count_in = cnt_m1;
      end
      if (cmd.pop_load) begin
         {top_row_in, top_col_in, top_tried_in} = stk_rdata_ff;
      end
      if (cmd.pop_last) begin
         count_in = '0;
      end
      if (cmd.fin_emit) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b1;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      top_row_ff   <= top_row_in;
      top_col_ff   <= top_col_in;
      top_tried_ff <= top_tried_in;
   end

   // output register
   logic    emit;
   rsp_type emit_data;

   always_comb begin
      emit      = cmd.wall_wr || cmd.new_wr || cmd.fin_emit;
      emit_data = '0;
      if (cmd.wall_wr) begin
         emit_data.cell_index = IDX_W'(widx_ff);
      end else if (cmd.new_wr) begin
         emit_data.cell_index = IDX_W'(nidx_ff);
         emit_data.last       = 1'b1;
      end else begin
         emit_data.finished = 1'b1;
         emit_data.last     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.tried_hit  = top_tried_ff[req_data.direction];
      status.maze_done  = done_ff;
      status.tgt_ok     = tgt_ok_ff;
      status.cell_open  = grid_rdata_ff;
      status.all_tried  = (top_tried_ff == ALL_TRIED);
      status.count_one  = (count_ff == CNTW'(1));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      status.clear_last = (clr_addr_ff == LAST_A);
   end

endmodule

// ===== hw/rtl/grid_maze_carver_top.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_type: operation, direction
// rsp_      out        rsp_valid/rsp_stall  rsp_type: cell_index, finished, last
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata (start_row, start_col)
//
// Steps: an ignored draw leaves the sequencer idle; a draw that carves runs the index multiply,
// grid read, test and two grid writes; each pop adds a stack memory read.
// A start request runs a clearing pass over the grid memory, all GRID_ROWS*GRID_COLS cells,
// then opens the start cell, or reports finished when the start cell is not an inner one.
// Reset: synchronous; grid contents are left as they are, the next start clears them.
// Stalls: results sit in an output register; a full register holds the sequencer.
module grid_maze_carver_top import gmc_pkg::*; #(
   parameter int GRID_ROWS   = 25,
   parameter int GRID_COLS   = 25,
   parameter int STACK_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // registers are always writable; the host writes only while idle
   assign csr_ready = 1'b1;

   // sequencer: one request at a time, draws walk the carve / pop steps
   gmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // grid memory, cell stack, index math and output register
   gmc_datapath #(
      .GRID_ROWS   (GRID_ROWS),
      .GRID_COLS   (GRID_COLS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/gmc_checker.sv =====
module gmc_checker import gmc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a done result closes its request and carries no cell
   a_finish_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finished |-> rsp_data.last && (rsp_data.cell_index == '0))
      else $error("finished result malformed");

   // taking a wall cell brings the new cell right after
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last
      |=> rsp_valid && rsp_data.last && !rsp_data.finished)
      else $error("carve pair broken");

   // no request is taken in the middle of a carve pair
   a_busy_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("request accepted during carve");

   // sequencer comes out of reset ready
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_stall)
      else $error("busy after reset");

endmodule

bind grid_maze_carver_top gmc_checker u_gmc_checker (.*);

// ===== tb/sv/testbench.sv =====
module testbench;
   import gmc_pkg::*;

   localparam int GRID_ROWS     = 25;
   localparam int GRID_COLS     = 25;
   localparam int STACK_DEPTH   = 128;
   localparam int CLK_HALF      = 6;
   localparam int ITEM_TOTAL    = 1400;
   // Quiet time before a register write: a start clears the whole grid and a
   // pop cascade can walk the full stack without producing a result.
   localparam int SETTLE_CYCLES = 2 * GRID_ROWS * GRID_COLS + 2 * STACK_DEPTH;
   localparam int RUN_DRAW_MAX  = 5000;
   localparam int TIMEOUT_CYC   = 1_500_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // Idle odds in percent per cycle, changed by the stimulus per phase.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   // Requests that changed the carver state; ignored draws do not count.
   int item_count   = 0;

   grid_maze_carver_top #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow of the carver: grid, backtrack stack and start registers.
   // note_request() advances it per accepted request and queues the cells the
   // block must report; check_result() matches them in order.
   class carve_scoreboard;
      bit               open_map [GRID_ROWS*GRID_COLS];
      int unsigned      path_cell [STACK_DEPTH];
      logic [3:0]       path_tried [STACK_DEPTH];
      int unsigned      path_len;
      bit               done;
      logic [CFG_W-1:0] row0;
      logic [CFG_W-1:0] col0;
      rsp_type          expected_cells [$];
      int unsigned      failures;

      function new();
         foreach (open_map[i]) open_map[i] = 1'b0;
         path_len = 0;
         done     = 1'b1;
         row0     = 5'd1;
         col0     = 5'd1;
         failures = 0;
      endfunction

      function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CFG_START_ROW) begin
            row0 = val;
         end else if (idx == CFG_START_COL) begin
            col0 = val;
         end
      endfunction

      function bit on_inner(int r, int c);
         return r > 0 && r < GRID_ROWS - 1 && c > 0 && c < GRID_COLS - 1;
      endfunction

      function void queue_result(int unsigned idx, logic fin, logic lst);
         rsp_type e;
         e.cell_index = IDX_W'(idx);
         e.finished   = fin;
         e.last       = lst;
         expected_cells = {expected_cells, e};
      endfunction

      // Returns 1 when the request changed the carver state.
      function bit note_request(req_type r);
         int          cr;
         int          cc;
         int          dr;
         int          dc;
         int unsigned top;
         int unsigned nidx;
         int unsigned widx;
         logic [3:0]  dir_bit;
         if (r.operation == OP_START) begin
            foreach (open_map[i]) open_map[i] = 1'b0;
            path_len = 0;
            cr = int'(row0);
            cc = int'(col0);
            if (!on_inner(cr, cc)) begin
               done = 1'b1;
               queue_result(0, 1'b1, 1'b1);
               return 1'b1;
            end
            nidx          = cr * GRID_COLS + cc;
            open_map[nidx] = 1'b1;
            path_cell[0]  = nidx;
            path_tried[0] = 4'h0;
            path_len      = 1;
            done          = 1'b0;
            return 1'b1;
         end
         if (done || path_len == 0) return 1'b0;
         top     = path_len - 1;
         dir_bit = 4'b0001 << r.direction;
         if ((path_tried[top] & dir_bit) != 4'h0) return 1'b0;
         path_tried[top] = path_tried[top] | dir_bit;
         cr = path_cell[top] / GRID_COLS;
         cc = path_cell[top] % GRID_COLS;
         dr = 0;
         dc = 0;
         case (r.direction)
            DIR_ROW_INC: dr = 2;
            DIR_COL_INC: dc = 2;
            DIR_ROW_DEC: dr = -2;
            default:     dc = -2;
         endcase
         if (on_inner(cr + dr, cc + dc)) begin
            nidx = (cr + dr) * GRID_COLS + (cc + dc);
            // a full stack turns the move into a blocked one
            if (!open_map[nidx] && path_len < STACK_DEPTH) begin
               widx                 = (cr + dr / 2) * GRID_COLS + (cc + dc / 2);
               open_map[widx]       = 1'b1;
               open_map[nidx]       = 1'b1;
               path_cell[path_len]  = nidx;
               path_tried[path_len] = 4'h0;
               path_len++;
               queue_result(widx, 1'b0, 1'b0);
               queue_result(nidx, 1'b0, 1'b1);
               return 1'b1;
            end
         end
         while (path_len > 0 && path_tried[path_len-1] == ALL_TRIED) path_len--;
         if (path_len == 0) begin
            done = 1'b1;
            queue_result(0, 1'b1, 1'b1);
         end
         return 1'b1;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_cells.size() == 0) begin
            $error("unexpected result: cell_index %0d finished %0b last %0b",
                   got.cell_index, got.finished, got.last);
            failures++;
            return;
         end
         want = expected_cells.pop_front();
         if (got.cell_index !== want.cell_index) begin
            $error("cell_index: expected %0d actual %0d", want.cell_index, got.cell_index);
            failures++;
         end
         if (got.finished !== want.finished) begin
            $error("finished: expected %0b actual %0b", want.finished, got.finished);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b actual %0b", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   carve_scoreboard sb = new();

   // 12-unit clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Result side: take a result at each edge with valid and no stall, then
   // roll the stall for the next cycle (one NBA per edge).
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         sb.check_result(rsp_data);
      end
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Hard stop if the block hangs.
   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYC);
      $display("grid_maze_carver_top: mismatch");
      $finish;
   end

   // Present one request and hold it until accepted; valid stays high so a
   // back-to-back request needs no extra edge.
   task automatic send_req(logic op, logic [1:0] dir);
      req_type r;
      r.operation = op;
      r.direction = dir;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (sb.note_request(r)) item_count++;
   endtask

   task automatic sender_gap();
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drop valid and wait for every queued result, then optionally sit quiet
   // long enough for a silent clear or pop cascade to finish.
   task automatic wait_results(int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_cells.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Register writes only happen with the block quiet.
   task automatic set_start(logic [CFG_W-1:0] row, logic [CFG_W-1:0] col);
      wait_results(SETTLE_CYCLES);
      csr_write(CFG_START_ROW, row);
      csr_write(CFG_START_COL, col);
   endtask

   // Mostly inner start cells; now and then a border or out-of-range one.
   task automatic set_random_start();
      logic [CFG_W-1:0] row;
      logic [CFG_W-1:0] col;
      row = CFG_W'($urandom_range(1, GRID_ROWS - 2));
      col = CFG_W'($urandom_range(1, GRID_COLS - 2));
      if ($urandom_range(99) < 20) begin
         case ($urandom_range(3))
            0:       row = '0;
            1:       col = CFG_W'(GRID_COLS - 1);
            2:       row = '1;
            default: col = CFG_W'($urandom_range(31));
         endcase
      end
      set_start(row, col);
   endtask

   // Direction for the next draw. Mostly an untried one at the top cell so
   // the walk gets deep; snake order sweeps rows to fill the stack.
   function automatic logic [1:0] pick_direction(bit snake);
      logic [3:0] untried;
      logic [1:0] sweep [4];
      int         n;
      int         k;
      untried = 4'h0;
      sweep   = '{DIR_COL_INC, DIR_COL_DEC, DIR_ROW_INC, DIR_ROW_DEC};
      if (!sb.done && sb.path_len != 0) untried = ~sb.path_tried[sb.path_len-1];
      if (untried == 4'h0 || $urandom_range(99) < (snake ? 2 : 10)) begin
         return 2'($urandom_range(3));
      end
      if (snake) begin
         for (k = 0; k < 4; k++) begin
            if (untried[sweep[k]]) return sweep[k];
         end
      end
      n = $urandom_range($countones(untried) - 1);
      for (k = 0; k < 4; k++) begin
         if (untried[k]) begin
            if (n == 0) return 2'(k);
            n--;
         end
      end
      return DIR_ROW_INC;
   endfunction

   // One maze: a start, then draws until done, the cap, or the item target.
   // Uncapped runs never restart, so they carve exactly one full maze.
   task automatic carve_run(bit snake, bit uncapped, int cap, int target);
      int draws;
      draws = 0;
      send_req(OP_START, 2'($urandom_range(3)));
      sender_gap();
      while (!sb.done && draws < cap && (uncapped || item_count < target)) begin
         if (!uncapped && $urandom_range(199) == 0) begin
            // abandon the walk and restart from the same cell
            send_req(OP_START, 2'($urandom_range(3)));
         end else begin
            send_req(OP_DRAW, pick_direction(snake));
         end
         draws++;
         sender_gap();
         if ($urandom_range(99) == 0) wait_results(0);
      end
      // draws after completion are dropped by the block
      if (sb.done) begin
         repeat ($urandom_range(3)) begin
            send_req(OP_DRAW, 2'($urandom_range(3)));
            sender_gap();
         end
      end
   endtask

   initial begin
      int p;
      int target;
      bit first;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      req_idle_pct = 20;
      rsp_idle_pct = 30;
      set_start(5'd1, 5'd1);
      send_req(OP_DRAW, DIR_ROW_INC);      // idle after reset: dropped
      send_req(OP_START, DIR_COL_DEC);
      send_req(OP_DRAW, DIR_ROW_DEC);      // off the grid, marked tried
      send_req(OP_DRAW, DIR_ROW_DEC);      // already tried: no effect
      send_req(OP_DRAW, DIR_COL_DEC);      // off the grid
      send_req(OP_DRAW, DIR_ROW_INC);      // carve down
      send_req(OP_DRAW, DIR_ROW_DEC);      // target already open
      send_req(OP_DRAW, DIR_COL_DEC);
      send_req(OP_DRAW, DIR_ROW_INC);      // carve again
      wait_results(0);                     // sender holds until all results land
      send_req(OP_START, DIR_ROW_INC);     // restart mid-walk
      send_req(OP_DRAW, DIR_COL_INC);
      set_start(5'd0, 5'd1);               // border start: finishes at once
      send_req(OP_START, DIR_COL_INC);
      send_req(OP_DRAW, DIR_COL_INC);      // after done: dropped
      set_start(5'd31, 5'd24);
      send_req(OP_START, DIR_ROW_DEC);
      set_start(5'd24, 5'd31);
      send_req(OP_START, DIR_ROW_INC);
      set_start(5'd5, 5'd0);
      send_req(OP_START, DIR_COL_INC);
      set_start(5'd23, 5'd23);             // far inner corner
      send_req(OP_START, DIR_ROW_INC);
      send_req(OP_DRAW, DIR_ROW_INC);
      send_req(OP_DRAW, DIR_COL_INC);
      send_req(OP_DRAW, DIR_ROW_DEC);
      send_req(OP_DRAW, DIR_COL_DEC);

      // ---- random phases ----
      // phase 0: sender idles little, receiver a lot; phase 1 the reverse;
      // phase 2 no idling. Each phase opens with a long run: a full guided
      // maze, a capped one from the far corner, then a row sweep that
      // overflows the stack. The last phase's full maze is about 600 items,
      // so the earlier targets leave room for it.
      item_count = 0;
      for (p = 0; p < 3; p++) begin
         req_idle_pct = (p == 0) ? 9 : (p == 1) ? 58 : 0;
         rsp_idle_pct = (p == 0) ? 58 : (p == 1) ? 9 : 0;
         target       = (p == 2) ? ITEM_TOTAL : ITEM_TOTAL * (p + 1) / 4;
         first        = 1'b1;
         while (item_count < target) begin
            if (first && p == 0) begin
               set_start(5'd1, 5'd1);
               carve_run(1'b0, 1'b1, RUN_DRAW_MAX, target);
            end else if (first && p == 1) begin
               set_start(5'd23, 5'd23);
               carve_run(1'b0, 1'b0, $urandom_range(100, 300), target);
            end else if (first) begin
               set_start(5'd1, 5'd1);
               carve_run(1'b1, 1'b1, RUN_DRAW_MAX, target);
            end else begin
               set_random_start();
               carve_run(1'b0, 1'b0, $urandom_range(10, 300), target);
            end
            first = 1'b0;
         end
      end

      wait_results(SETTLE_CYCLES);
      if (sb.failures == 0 && sb.expected_cells.size() == 0) begin
         $display("grid_maze_carver_top: match");
      end else begin
         $display("grid_maze_carver_top: mismatch");
      end
      $finish;
   end

endmodule
